FILE: sv/f4cs_pkg.sv
// f4cs_pkg: shared types, constants and helper functions for the Fletcher-4 stream core.
// No dependencies; every other file of the block imports it.
package f4cs_pkg;

   localparam int WORD_W          = 32;
   localparam int SUM_W           = 64;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Pair-term widths: e+o, 2e+o, 3e+o, 4e+o
   localparam int S1_W = WORD_W + 1;
   localparam int S2_W = WORD_W + 2;
   localparam int S3_W = WORD_W + 3;
   localparam int S4_W = WORD_W + 3;

   typedef struct packed {
      logic [WORD_W-1:0] word_even;
      logic [WORD_W-1:0] word_odd;
      logic              first_pair;
      logic              last_pair;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum_a;
      logic [SUM_W-1:0] sum_b;
      logic [SUM_W-1:0] sum_c;
      logic [SUM_W-1:0] sum_d;
   } rsp_type;

   // One classified pair as held in the queue
   typedef struct packed {
      logic [S1_W-1:0] s1;
      logic [S2_W-1:0] s2;
      logic [S3_W-1:0] s3;
      logic [S4_W-1:0] s4;
      logic            first_pair;
      logic            last_pair;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type data;
   } qpush_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] c;
   } csa_type;

   function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // 3:2 carry-save compression, carries already shifted into place
   function automatic csa_type csa3(input logic [SUM_W-1:0] x,
                                    input logic [SUM_W-1:0] y,
                                    input logic [SUM_W-1:0] z);
      csa_type r;
      r.s = x ^ y ^ z;
      r.c = {((x[SUM_W-2:0] & y[SUM_W-2:0]) | (x[SUM_W-2:0] & z[SUM_W-2:0]) |
              (y[SUM_W-2:0] & z[SUM_W-2:0])), 1'b0};
      return r;
   endfunction

endpackage

FILE: sv/f4cs_front.sv
// f4cs_front: input acceptance, byte-order selection and per-pair term precompute.
// Depends on f4cs_pkg; feeds f4cs_queue.
module f4cs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_data,
   output logic              csr_ready,
   input  logic              req_valid,
   input  f4cs_pkg::req_type req_data,
   output logic              req_ready,
   input  f4cs_pkg::qstat_type qstat,
   output f4cs_pkg::qpush_type qpush
);
   import f4cs_pkg::*;

   logic              swap_ff, swap_in;
   logic [WORD_W-1:0] we, wo;
   logic [S2_W-1:0]   e3;

   assign csr_ready = 1'b1;
   assign swap_in   = (csr_valid && csr_ready) ? csr_data : swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
      end else begin
         swap_ff <= swap_in;
      end
   end

   assign req_ready = !qstat.full;

   always_comb begin
      we = swap_ff ? swap32(req_data.word_even) : req_data.word_even;
      wo = swap_ff ? swap32(req_data.word_odd)  : req_data.word_odd;
      e3 = {1'b0, we, 1'b0} + {2'b00, we};
      qpush.valid           = req_valid && req_ready;
      qpush.data.s1         = {1'b0, we} + {1'b0, wo};
      qpush.data.s2         = {1'b0, we, 1'b0} + {2'b00, wo};
      qpush.data.s3         = {1'b0, e3} + {3'b000, wo};
      qpush.data.s4         = {1'b0, we, 2'b00} + {3'b000, wo};
      qpush.data.first_pair = req_data.first_pair;
      qpush.data.last_pair  = req_data.last_pair;
   end

endmodule

FILE: sv/f4cs_queue.sv
// f4cs_queue: short FIFO between the front and the back end.
// Depends on f4cs_pkg.
module f4cs_queue #(
   parameter int DEPTH = f4cs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  f4cs_pkg::qpush_type qpush,
   input  logic                pop,
   output f4cs_pkg::qent_type  head,
   output f4cs_pkg::qstat_type qstat
);
   import f4cs_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qent_type        mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = qpush.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= qpush.data;
      end
   end

endmodule

FILE: sv/f4cs_back.sv
// f4cs_back: running sums, two words per cycle unless stalled, and the result
// output register. Depends on f4cs_pkg; drains f4cs_queue.
module f4cs_back (
   input  logic                clock,
   input  logic                reset,
   input  f4cs_pkg::qent_type  head,
   input  f4cs_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   output f4cs_pkg::rsp_type   rsp_data,
   input  logic                rsp_ready
);
   import f4cs_pkg::*;

   logic [SUM_W-1:0] acc_a_ff, acc_b_ff, acc_c_ff, acc_d_ff;
   logic [SUM_W-1:0] acc_a_in, acc_b_in, acc_c_in, acc_d_in;
   logic [SUM_W-1:0] a, b, c, d;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   csa_type          cx, cy, cz, dp, dq, dr, dt, bx;

   // Take the head unless it would produce a result with the output slot blocked
   assign pop = !qstat.empty && (!head.last_pair || !rsp_valid_ff || rsp_ready);

   // After a pair (e, o): a+=e+o, b+=2a+2e+o, c+=2b+3a+3e+o, d+=2c+3b+4a+4e+o
   always_comb begin
      a = head.first_pair ? '0 : acc_a_ff;
      b = head.first_pair ? '0 : acc_b_ff;
      c = head.first_pair ? '0 : acc_c_ff;
      d = head.first_pair ? '0 : acc_d_ff;

      bx = csa3(b, a << 1, SUM_W'(head.s2));

      cx = csa3(c, b << 1, a);
      cy = csa3(cx.s, cx.c, a << 1);
      cz = csa3(cy.s, cy.c, SUM_W'(head.s3));

      dp = csa3(d, c << 1, b);
      dq = csa3(b << 1, a << 2, SUM_W'(head.s4));
      dr = csa3(dp.s, dp.c, dq.s);
      dt = csa3(dr.s, dr.c, dq.c);

      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      acc_c_in = acc_c_ff;
      acc_d_in = acc_d_ff;
      if (pop) begin
         acc_a_in = a + SUM_W'(head.s1);
         acc_b_in = bx.s + bx.c;
         acc_c_in = cz.s + cz.c;
         acc_d_in = dt.s + dt.c;
      end

      if (pop && head.last_pair) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_a_ff     <= '0;
         acc_b_ff     <= '0;
         acc_c_ff     <= '0;
         acc_d_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_a_ff     <= acc_a_in;
         acc_b_ff     <= acc_b_in;
         acc_c_ff     <= acc_c_in;
         acc_d_ff     <= acc_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last_pair) begin
         rsp_data_ff.sum_a <= acc_a_in;
         rsp_data_ff.sum_b <= acc_b_in;
         rsp_data_ff.sum_c <= acc_c_in;
         rsp_data_ff.sum_d <= acc_d_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/fletcher4_checksum_stream_core.sv
// fletcher4_checksum_stream_core: top level of the Fletcher-4 checksum stream block.
// Depends on f4cs_pkg, f4cs_front, f4cs_queue and f4cs_back.
//
//   channel | ports                        | carries
//   --------+------------------------------+------------------------------------------
//   req     | req_valid/req_ready/req_data | one item: word pair plus first/last flags
//   rsp     | rsp_valid/rsp_ready/rsp_data | the four 64-bit sums, after a last pair
//   csr     | csr_valid/csr_ready/csr_data | swap_bytes bit, always ready
//
// One item per cycle sustained while the queue has room; a last pair taken into an empty queue
// is first written into the queue, then its sums are registered in the result output register.
// The back end folds both words of a pair into the sums together: carry-save trees for
// sums b, c and d, and each sum closed by one 64-bit add.
// Reset is synchronous: sums cleared, queue emptied, swap_bytes back to native order.
// A stalled rsp holds only the back end; req keeps being taken until the queue fills.
module fletcher4_checksum_stream_core #(
   parameter int QUEUE_DEPTH = f4cs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_data,
   output logic              csr_ready,
   input  logic              req_valid,
   input  f4cs_pkg::req_type req_data,
   output logic              req_ready,
   output logic              rsp_valid,
   output f4cs_pkg::rsp_type rsp_data,
   input  logic              rsp_ready
);
   import f4cs_pkg::*;

   qpush_type qpush;
   qstat_type qstat;
   qent_type  head;
   logic      pop;

   // Front: take items, apply byte order, precompute pair terms
   f4cs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .qstat     (qstat),
      .qpush     (qpush)
   );

   // Queue: decouple acceptance from summing
   f4cs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .qpush (qpush),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   // Back: advance the sums and hold a result until taken
   f4cs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule

FILE: sv/f4cs_checker.sv
// f4cs_checker: port-level assertions for fletcher4_checksum_stream_core, with its bind.
// Depends on f4cs_pkg and the top level's ports.
module f4cs_checker #(
   parameter int QUEUE_DEPTH = f4cs_pkg::QUEUE_DEPTH_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input f4cs_pkg::req_type req_data,
   input logic              req_ready,
   input logic              rsp_valid,
   input f4cs_pkg::rsp_type rsp_data,
   input logic              rsp_ready
);
   import f4cs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH + 2) + 1;

   // Results owed: last pairs taken minus results delivered
   logic [PW-1:0] owed_ff, owed_in;
   logic          take_last, give;

   assign take_last = req_valid && req_ready && req_data.last_pair;
   assign give      = rsp_valid && rsp_ready;

   always_comb begin
      owed_in = owed_ff;
      if (take_last && !give) begin
         owed_in = owed_ff + 1'b1;
      end else if (give && !take_last) begin
         owed_in = owed_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != '0)
      else $error("result shown with no last pair outstanding");

   a_owed_bound: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= PW'(QUEUE_DEPTH + 1))
      else $error("more results owed than the queue and output slot can hold");

endmodule

bind fletcher4_checksum_stream_core f4cs_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_f4cs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_data  (req_data),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_ready (rsp_ready)
);
